// ===== hdl/mstk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstk_pkg: shared types for the Kruskal minimum spanning tree block
// Word layouts, control group for the sorter cells and the sequencer states.
// ----------------------------------------------------------------------------
package mstk_pkg;

  localparam int NODE_BITS  = 6;
  localparam int COST_BITS  = 16;
  localparam int TOTAL_BITS = 24;

  typedef struct packed {
    logic [NODE_BITS-1:0]        end_a;
    logic [NODE_BITS-1:0]        end_b;
    logic signed [COST_BITS-1:0] cost;
    logic                        final_edge;
  } in_word_t;

  typedef struct packed {
    logic                         kind;
    logic [NODE_BITS-1:0]         low_node;
    logic [NODE_BITS-1:0]         high_node;
    logic signed [COST_BITS-1:0]  edge_cost;
    logic signed [TOTAL_BITS-1:0] tree_total;
    logic                         run_end;
  } out_word_t;

  // control broadcast to every sorter cell
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_MERGE,
    ST_TOTAL
  } state_t;

  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

endpackage

// ===== hdl/min_spanning_tree_kruskal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_spanning_tree_kruskal: Kruskal minimum spanning forest
// Edges are sorted on arrival in a row of insertion cells; after the final
// edge the row is drained head first and merged through node label cells.
// ----------------------------------------------------------------------------
//  channel  | ports                        | handshake
//  ---------+------------------------------+-------------------------------
//  input    | start, busy, item            | word taken when start && !busy
//  result   | result_strobe, result        | one-cycle strobe per word, no stall
//
// Loading: one edge word per cycle; the sorter cell row inserts in place.
// Burst: after the final edge, each stored edge takes a head read and label
//   lookup, then a merge; an empty row check then leads to the total word;
//   busy throughout. Each result word is registered from its merge or total state.
// Edges beyond MAX_EDGES are dropped; a dropped final edge still starts the
//   burst. Labels, count and total return to reset values after the total.
// Reset (rst, synchronous) empties the row and gives each node its own label.
// The receiver cannot stall: each result word is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module min_spanning_tree_kruskal #(
  parameter int MAX_EDGES   = 256,
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mstk_pkg::in_word_t  item,
  output logic                result_strobe,
  output mstk_pkg::out_word_t result
);

  localparam int WB  = WEIGHT_BITS;
  localparam int NB  = mstk_pkg::NODE_BITS;
  localparam int CB  = mstk_pkg::COST_BITS;
  localparam int TB  = mstk_pkg::TOTAL_BITS;
  localparam int CW  = $clog2(MAX_EDGES + 1);
  localparam int NIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int SW  = ((WB > TB) ? WB : TB) + 1;   // sum width, one spare bit

  mstk_pkg::state_t state, state_next;

  logic [CW-1:0]       edge_count;
  logic [NB-1:0]       labels [MAX_NODES];
  logic signed [TB-1:0] running_total;

  // registered head edge and its label lookups
  logic [NB-1:0]        e_lo, e_hi, la, lb;
  logic signed [WB-1:0] e_cost;
  logic                 e_ok;

  logic accept;
  assign busy   = (state != mstk_pkg::ST_LOAD);
  assign accept = start && !busy;

  // -- incoming edge, endpoints ordered, weight trimmed or zero-extended to WEIGHT_BITS
  logic [NB-1:0]        in_lo, in_hi;
  logic signed [WB-1:0] in_cost;
  assign in_lo = (item.end_a < item.end_b) ? item.end_a : item.end_b;
  assign in_hi = (item.end_a < item.end_b) ? item.end_b : item.end_a;

  generate
    if (WB <= CB) begin : g_trim
      assign in_cost = item.cost[WB-1:0];
    end else begin : g_zext
      assign in_cost = {{(WB-CB){1'b0}}, item.cost};
    end
  endgenerate

  // -- sorter cell row
  mstk_pkg::cell_ctl_t  ctl;
  logic                 c_move  [MAX_EDGES];
  logic                 c_valid [MAX_EDGES];
  logic signed [WB-1:0] c_cost  [MAX_EDGES];
  logic [NB-1:0]        c_lo    [MAX_EDGES];
  logic [NB-1:0]        c_hi    [MAX_EDGES];

  assign ctl.insert = accept && (edge_count < CW'(MAX_EDGES));
  assign ctl.pop    = (state == mstk_pkg::ST_READ) && (edge_count != '0);

  genvar gi;
  generate
    for (gi = 0; gi < MAX_EDGES; gi++) begin : g_cell
      logic                 lm, lv, rv;
      logic signed [WB-1:0] lc, rc;
      logic [NB-1:0]        ll, lh, rl, rh;
      if (gi == 0) begin : g_head
        assign lm = 1'b0;
        assign lv = 1'b0;
        assign lc = '0;
        assign ll = '0;
        assign lh = '0;
      end else begin : g_body
        assign lm = c_move[gi-1];
        assign lv = c_valid[gi-1];
        assign lc = c_cost[gi-1];
        assign ll = c_lo[gi-1];
        assign lh = c_hi[gi-1];
      end
      if (gi == MAX_EDGES - 1) begin : g_tail
        assign rv = 1'b0;
        assign rc = '0;
        assign rl = '0;
        assign rh = '0;
      end else begin : g_next
        assign rv = c_valid[gi+1];
        assign rc = c_cost[gi+1];
        assign rl = c_lo[gi+1];
        assign rh = c_hi[gi+1];
      end
      mstk_cell #(.WB(WB)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .new_cost   (in_cost),
        .new_lo     (in_lo),
        .new_hi     (in_hi),
        .left_move  (lm),
        .left_valid (lv),
        .left_cost  (lc),
        .left_lo    (ll),
        .left_hi    (lh),
        .right_valid(rv),
        .right_cost (rc),
        .right_lo   (rl),
        .right_hi   (rh),
        .move       (c_move[gi]),
        .valid      (c_valid[gi]),
        .cost       (c_cost[gi]),
        .lo         (c_lo[gi]),
        .hi         (c_hi[gi])
      );
    end
  endgenerate

  // -- head lookup: endpoints valid and distinct, then their labels
  //    (compared one bit wider so that MAX_NODES = 2**NB still fits)
  logic head_in_range;
  assign head_in_range = ({1'b0, c_lo[0]} < (NB+1)'(MAX_NODES)) &&
                         ({1'b0, c_hi[0]} < (NB+1)'(MAX_NODES));

  logic joins;
  assign joins = (state == mstk_pkg::ST_MERGE) && e_ok && (la != lb);

  // saturating running total
  logic signed [SW-1:0] sum;
  logic signed [TB-1:0] sum_sat;
  assign sum = {{(SW-TB){running_total[TB-1]}}, running_total}
             + {{(SW-WB){e_cost[WB-1]}}, e_cost};
  always_comb begin
    if (sum > SW'(8388607))        sum_sat = {1'b0, {(TB-1){1'b1}}};
    else if (sum < -SW'(8388608))  sum_sat = {1'b1, {(TB-1){1'b0}}};
    else                           sum_sat = sum[TB-1:0];
  end

  logic signed [CB-1:0] e_cost_out;
  generate
    if (WB >= CB) begin : g_cut
      assign e_cost_out = e_cost[CB-1:0];
    end else begin : g_sext
      assign e_cost_out = {{(CB-WB){e_cost[WB-1]}}, e_cost};
    end
  endgenerate

  // -- sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= mstk_pkg::ST_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mstk_pkg::ST_LOAD:  if (accept && item.final_edge) state_next = mstk_pkg::ST_READ;
      mstk_pkg::ST_READ:  state_next = (edge_count == '0) ? mstk_pkg::ST_TOTAL
                                                          : mstk_pkg::ST_MERGE;
      mstk_pkg::ST_MERGE: state_next = mstk_pkg::ST_READ;
      mstk_pkg::ST_TOTAL: state_next = mstk_pkg::ST_LOAD;
      default:            state_next = mstk_pkg::ST_LOAD;
    endcase
  end

  // count: loads up, drains down as the head is popped
  always_ff @(posedge clk) begin
    if (rst || state == mstk_pkg::ST_TOTAL) begin
      edge_count <= '0;
    end else if (ctl.insert) begin
      edge_count <= edge_count + CW'(1);
    end else if (ctl.pop) begin
      edge_count <= edge_count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      e_lo   <= c_lo[0];
      e_hi   <= c_hi[0];
      e_cost <= c_cost[0];
      e_ok   <= head_in_range && (c_lo[0] != c_hi[0]);
      la     <= labels[c_lo[0][NIW-1:0]];
      lb     <= labels[c_hi[0][NIW-1:0]];
    end
  end

  // node label cells: every node carrying lb takes la on a join
  genvar ni;
  generate
    for (ni = 0; ni < MAX_NODES; ni++) begin : g_node
      always_ff @(posedge clk) begin
        if (rst || state == mstk_pkg::ST_TOTAL) begin
          labels[ni] <= NB'(ni);
        end else if (joins && labels[ni] == lb) begin
          labels[ni] <= la;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst || state == mstk_pkg::ST_TOTAL) running_total <= '0;
    else if (joins)                          running_total <= sum_sat;
  end

  // -- result register
  always_ff @(posedge clk) begin
    if (rst) result_strobe <= 1'b0;
    else     result_strobe <= joins || (state == mstk_pkg::ST_TOTAL);
  end

  always_ff @(posedge clk) begin
    if (state == mstk_pkg::ST_TOTAL) begin
      result.kind       <= mstk_pkg::KIND_TOTAL;
      result.low_node   <= '0;
      result.high_node  <= '0;
      result.edge_cost  <= '0;
      result.tree_total <= running_total;
      result.run_end    <= 1'b1;
    end else begin
      result.kind       <= mstk_pkg::KIND_EDGE;
      result.low_node   <= e_lo;
      result.high_node  <= e_hi;
      result.edge_cost  <= e_cost_out;
      result.tree_total <= sum_sat;
      result.run_end    <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    edge_count <= CW'(MAX_EDGES))
    else $error("edge count beyond store depth");

  a_total_ends_burst: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.run_end |-> state == mstk_pkg::ST_LOAD && edge_count == '0)
    else $error("total word without return to load");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    state == mstk_pkg::ST_LOAD && result_strobe |-> result.run_end)
    else $error("edge word while loading");
`endif

endmodule

// ===== hdl/mstk_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstk_cell: one slot of the insertion sorter
// Holds one edge. Insert shifts larger entries one place down the row;
// pop shifts the whole row one place towards the head.
// ----------------------------------------------------------------------------
module mstk_cell #(
  parameter int WB = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mstk_pkg::cell_ctl_t                 ctl,
  input  logic signed [WB-1:0]                new_cost,
  input  logic [mstk_pkg::NODE_BITS-1:0]      new_lo,
  input  logic [mstk_pkg::NODE_BITS-1:0]      new_hi,
  input  logic                                left_move,
  input  logic                                left_valid,
  input  logic signed [WB-1:0]                left_cost,
  input  logic [mstk_pkg::NODE_BITS-1:0]      left_lo,
  input  logic [mstk_pkg::NODE_BITS-1:0]      left_hi,
  input  logic                                right_valid,
  input  logic signed [WB-1:0]                right_cost,
  input  logic [mstk_pkg::NODE_BITS-1:0]      right_lo,
  input  logic [mstk_pkg::NODE_BITS-1:0]      right_hi,
  output logic                                move,
  output logic                                valid,
  output logic signed [WB-1:0]                cost,
  output logic [mstk_pkg::NODE_BITS-1:0]      lo,
  output logic [mstk_pkg::NODE_BITS-1:0]      hi
);

  // slot gives way to the new edge: empty, or strictly heavier (keeps ties stable)
  assign move = !valid || (cost > new_cost);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.pop) begin
      valid <= right_valid;
    end else if (ctl.insert && move) begin
      valid <= left_move ? left_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      cost <= right_cost;
      lo   <= right_lo;
      hi   <= right_hi;
    end else if (ctl.insert && move) begin
      if (left_move) begin
        cost <= left_cost;
        lo   <= left_lo;
        hi   <= left_hi;
      end else begin
        cost <= new_cost;
        lo   <= new_lo;
        hi   <= new_hi;
      end
    end
  end

endmodule

// ===== test/min_spanning_tree_kruskal_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_spanning_tree_kruskal_tb: self-checking bench for the Kruskal block
// Edge words go in as directed and random graphs; a local forest builder predicts the tree
// edge words and the closing total, checked in order as each strobe arrives.
// ----------------------------------------------------------------------------
module min_spanning_tree_kruskal_tb;

  localparam int MAX_EDGES = 256;
  localparam int MAX_NODES = 64;
  localparam int TOT_MAX   = 8388607;
  localparam int TOT_MIN   = -8388608;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  mstk_pkg::in_word_t  item = '0;
  logic                result_strobe;
  mstk_pkg::out_word_t result;

  min_spanning_tree_kruskal i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // pending edge words; a zero marker word with pause set asks for a drain
  mstk_pkg::in_word_t  edge_queue[$];
  bit                  pause_queue[$];
  mstk_pkg::out_word_t tree_words[$];
  int                  mismatches = 0;
  bit                  stim_done = 1'b0;

  // predictor state: the graph loaded so far
  logic [5:0]  g_lo[MAX_EDGES];
  logic [5:0]  g_hi[MAX_EDGES];
  int          g_cost[MAX_EDGES];
  int          g_count = 0;

  // store one edge word and, on the final one, build the forest
  task automatic predict_forest(input mstk_pkg::in_word_t w);
    int ord[MAX_EDGES];
    int label[MAX_NODES];
    int i, j, key, e, la, lb, n, total, emitted;
    mstk_pkg::out_word_t o;
    if (g_count < MAX_EDGES) begin
      g_lo[g_count]   = (w.end_a < w.end_b) ? w.end_a : w.end_b;
      g_hi[g_count]   = (w.end_a < w.end_b) ? w.end_b : w.end_a;
      g_cost[g_count] = w.cost;
      g_count++;
    end
    if (!w.final_edge) return;
    // stable insertion sort of indices by weight
    for (i = 0; i < g_count; i++) begin
      key = i;
      j = i;
      while (j > 0 && g_cost[ord[j-1]] > g_cost[key]) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = key;
    end
    for (n = 0; n < MAX_NODES; n++) label[n] = n;
    total = 0;
    emitted = 0;
    for (i = 0; i < g_count; i++) begin
      e = ord[i];
      if (g_lo[e] == g_hi[e]) continue;
      la = label[g_lo[e]];
      lb = label[g_hi[e]];
      if (la == lb) continue;
      for (n = 0; n < MAX_NODES; n++) if (label[n] == lb) label[n] = la;
      total += g_cost[e];
      if (total > TOT_MAX) total = TOT_MAX;
      if (total < TOT_MIN) total = TOT_MIN;
      if (emitted < 63) begin
        o.kind       = mstk_pkg::KIND_EDGE;
        o.low_node   = g_lo[e];
        o.high_node  = g_hi[e];
        o.edge_cost  = 16'(g_cost[e]);
        o.tree_total = 24'(total);
        o.run_end    = 1'b0;
        tree_words.push_back(o);
        emitted++;
      end
    end
    o = '0;
    o.kind       = mstk_pkg::KIND_TOTAL;
    o.tree_total = 24'(total);
    o.run_end    = 1'b1;
    tree_words.push_back(o);
    g_count = 0;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // driver: bursts of random length, random gaps, drain on marker
  int  burst_left = 0;
  int  gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_forest(item);
        edge_queue.pop_front();
        pause_queue.pop_front();
      end
      if (start && busy) begin
        // hold the current word until taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (edge_queue.size() != 0 && pause_queue[0]) begin
        // drain point: wait for every expected word, then let pending work settle
        start <= 1'b0;
        if (tree_words.size() == 0 && !busy) begin
          edge_queue.pop_front();
          pause_queue.pop_front();
        end
      end else if (edge_queue.size() != 0) begin
        item  <= edge_queue[0];
        start <= 1'b1;
        if (burst_left <= 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // monitor: every strobe must match the oldest expected word
  always @(posedge clk) begin
    mstk_pkg::out_word_t w;
    if (!rst && result_strobe) begin
      if (tree_words.size() == 0) begin
        report_mismatch("unexpected word", 64'(result), 64'(0));
      end else begin
        w = tree_words.pop_front();
        if (result.kind !== w.kind)
          report_mismatch("kind", 64'(result.kind), 64'(w.kind));
        if (result.low_node !== w.low_node)
          report_mismatch("low_node", 64'(result.low_node), 64'(w.low_node));
        if (result.high_node !== w.high_node)
          report_mismatch("high_node", 64'(result.high_node), 64'(w.high_node));
        if (result.edge_cost !== w.edge_cost)
          report_mismatch("edge_cost", 64'(result.edge_cost), 64'(w.edge_cost));
        if (result.tree_total !== w.tree_total)
          report_mismatch("tree_total", 64'(result.tree_total), 64'(w.tree_total));
        if (result.run_end !== w.run_end)
          report_mismatch("run_end", 64'(result.run_end), 64'(w.run_end));
      end
    end
  end

  task automatic add_edge(input int a, input int b, input int c, input bit fin);
    mstk_pkg::in_word_t w;
    w.end_a = 6'(a);
    w.end_b = 6'(b);
    w.cost = 16'(c);
    w.final_edge = fin;
    edge_queue.push_back(w);
    pause_queue.push_back(1'b0);
  endtask

  task automatic add_drain();
    edge_queue.push_back('0);
    pause_queue.push_back(1'b1);
  endtask

  // one random graph; mostly few nodes so that cycles and ties are common
  task automatic add_graph(input int edges, input int nodes, input bit wide_cost);
    int k, c;
    for (k = 0; k < edges; k++) begin
      c = wide_cost ? $signed(16'($urandom)) : $urandom_range(0, 9) - 4;
      add_edge($urandom_range(0, nodes - 1), $urandom_range(0, nodes - 1), c,
               k == edges - 1);
    end
  endtask

  initial begin
    int sent, n;
    // directed: extremes, self-loop, ties, node 0 and 63, empty tree
    add_edge(0, 0, 5, 1'b1);                 // self-loop alone: total only
    add_edge(63, 0, 32767, 1'b0);
    add_edge(0, 63, -32768, 1'b0);           // parallel edge, lighter
    add_edge(5, 5, -1, 1'b0);
    add_edge(1, 2, 7, 1'b0);
    add_edge(2, 3, 7, 1'b0);                 // tie keeps arrival order
    add_edge(3, 1, 7, 1'b1);
    add_drain();
    for (n = 0; n < 6; n++) add_edge(n, n + 1, 32767, n == 5);
    add_edge(42, 21, -32768, 1'b1);
    // full chain: 63 heavy edges along a chain
    for (n = 0; n < 63; n++) add_edge(n, n + 1, 32767, 1'b0);
    add_edge(62, 63, 32767, 1'b1);
    for (n = 0; n < 63; n++) add_edge(n + 1, n, -32768, n == 62);
    // store full: 260 input words, dropped tail, final dropped too
    for (n = 0; n < 260; n++)
      add_edge($urandom_range(0, 63), $urandom_range(0, 63),
               $signed(16'($urandom)), n == 259);
    add_drain();
    sent = edge_queue.size();
    while (sent < 400) begin
      n = $urandom_range(1, 12);
      add_graph(n, ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(2, 10),
                $urandom_range(0, 1));
      sent += n;
      if ($urandom_range(0, 9) == 0) add_drain();
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done);
    while (tree_words.size() != 0 || busy) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && tree_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== min_spanning_tree_kruskal.f =====
hdl/mstk_pkg.sv
hdl/mstk_cell.sv
hdl/min_spanning_tree_kruskal.sv
test/min_spanning_tree_kruskal_tb.sv
